// File: hdl/vcso_pkg.sv
`default_nettype none

package vcso_pkg;

    localparam int OUTLINE_K     = 7864;
    localparam int OUTLINE_SCALE = 4 * OUTLINE_K;
    localparam int OUTLINE_ROUND = 32768;

    localparam logic [15:0] SHADE_LOW  = 16'd6554;
    localparam logic [15:0] SHADE_HIGH = 16'd58982;
    localparam logic [15:0] SHADE_MAX  = 16'hFFFF;

    localparam int PRESCALE_BITS = 24;
    localparam int MAG_W         = 33;
    localparam int VEC_W         = PRESCALE_BITS + 1;
    localparam int SQ_W          = 2 * PRESCALE_BITS;
    localparam int PR_W          = VEC_W + 16;
    localparam int L2_W          = SQ_W + 2;
    localparam int P_W           = PR_W + 1;
    localparam int RAD_W         = L2_W + 12;
    localparam int ROOT_W        = RAD_W / 2;
    localparam int NUM_W         = (P_W - 1) + 8;
    localparam int QUO_W         = 18;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_X     = 3'd0,
        CFG_LIGHT_Y     = 3'd1,
        CFG_LIGHT_Z     = 3'd2,
        CFG_DIRECTIONAL = 3'd3,
        CFG_SHADING     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] outline_x;
        logic signed [31:0] outline_y;
        logic signed [31:0] outline_z;
        logic               last;
        logic               shade_en;
        logic               zero;
        logic               neg;
    } t_side;

endpackage

`default_nettype wire

// File: hdl/vcso_sqrt.sv
`default_nettype none

module vcso_sqrt (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [vcso_pkg::RAD_W-1:0]    i_rad,
    input  wire [vcso_pkg::NUM_W-1:0]    i_num,
    input  wire vcso_pkg::t_side         i_side,
    output logic                         o_valid,
    output logic [vcso_pkg::ROOT_W-1:0]  o_root,
    output logic [vcso_pkg::NUM_W-1:0]   o_num,
    output vcso_pkg::t_side              o_side
);

    localparam int RAD_W  = vcso_pkg::RAD_W;
    localparam int ROOT_W = vcso_pkg::ROOT_W;
    localparam int NUM_W  = vcso_pkg::NUM_W;

    logic                  r_valid [ROOT_W];
    logic [RAD_W-1:0]      r_rad   [ROOT_W];
    logic [ROOT_W+1:0]     r_rem   [ROOT_W];
    logic [ROOT_W-1:0]     r_root  [ROOT_W];
    logic [NUM_W-1:0]      r_num   [ROOT_W];
    vcso_pkg::t_side       r_side  [ROOT_W];

    // one root bit per stage, two radicand bits consumed
    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
        logic              p_valid;
        logic [RAD_W-1:0]  p_rad;
        logic [ROOT_W+1:0] p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [NUM_W-1:0]  p_num;
        vcso_pkg::t_side   p_side;
        logic [ROOT_W+3:0] w_cur;
        logic [ROOT_W+3:0] w_try;
        logic [ROOT_W+1:0] n_rem;
        logic [ROOT_W-1:0] n_root;

        if (j == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rad   = i_rad;
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_num   = i_num;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[j-1];
            assign p_rad   = r_rad[j-1];
            assign p_rem   = r_rem[j-1];
            assign p_root  = r_root[j-1];
            assign p_num   = r_num[j-1];
            assign p_side  = r_side[j-1];
        end

        always_comb begin
            w_cur = {p_rem, p_rad[RAD_W-1-2*j -: 2]};
            w_try = {2'b00, p_root, 2'b01};
            if (w_cur >= w_try) begin
                n_rem  = (ROOT_W+2)'(w_cur - w_try);
                n_root = {p_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_cur[ROOT_W+1:0];
                n_root = {p_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j]  <= p_rad;
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
                r_num[j]  <= p_num;
                r_side[j] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_num   = r_num[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

// File: hdl/vcso_div.sv
`default_nettype none

module vcso_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [vcso_pkg::NUM_W-1:0]    i_num,
    input  wire [vcso_pkg::ROOT_W-1:0]   i_den,
    input  wire vcso_pkg::t_side         i_side,
    output logic                         o_valid,
    output logic [vcso_pkg::QUO_W-1:0]   o_quo,
    output vcso_pkg::t_side              o_side
);

    localparam int NUM_W  = vcso_pkg::NUM_W;
    localparam int ROOT_W = vcso_pkg::ROOT_W;
    localparam int QUO_W  = vcso_pkg::QUO_W;

    logic                  r_valid [QUO_W];
    logic [NUM_W-1:0]      r_rem   [QUO_W];
    logic [ROOT_W-1:0]     r_den   [QUO_W];
    logic [QUO_W-1:0]      r_quo   [QUO_W];
    vcso_pkg::t_side       r_side  [QUO_W];

    // restoring division, one quotient bit per stage, top bit flags overflow
    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic              p_valid;
        logic [NUM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_den;
        logic [QUO_W-1:0]  p_quo;
        vcso_pkg::t_side   p_side;
        logic [NUM_W-1:0]  w_sub;
        logic [NUM_W-1:0]  n_rem;
        logic [QUO_W-1:0]  n_quo;

        if (j == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = i_num;
            assign p_den   = i_den;
            assign p_quo   = '0;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[j-1];
            assign p_rem   = r_rem[j-1];
            assign p_den   = r_den[j-1];
            assign p_quo   = r_quo[j-1];
            assign p_side  = r_side[j-1];
        end

        always_comb begin
            w_sub = NUM_W'(p_den) << (QUO_W - 1 - j);
            if (p_rem >= w_sub) begin
                n_rem = p_rem - w_sub;
                n_quo = {p_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = p_rem;
                n_quo = {p_quo[QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_den[j]  <= p_den;
                r_quo[j]  <= n_quo;
                r_side[j] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

`default_nettype wire

// File: hdl/vertex_cel_shade_and_outline.sv
`default_nettype none

// channel   dir  handshake                    payload
// vertex    in   i_vtx_valid / o_vtx_ready    position, normal, last mark
// result    out  o_res_valid / i_res_ready    outline, shade coordinate, last mark
// config    in   i_cfg_wr                     i_cfg_idx, i_cfg_data
//
// one vertex per cycle unless the output stalls; 4 front stages, 31 square root
// stages (one root bit each), 18 divider stages, one output register
// the square root chain sets the depth
// synchronous active low reset clears valid bits and light registers
// a stalled output freezes the whole pipe; nothing is lost or repeated

module vertex_cel_shade_and_outline (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr,
    input  wire [vcso_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [31:0]                           i_cfg_data,
    input  wire                                  i_vtx_valid,
    output logic                                 o_vtx_ready,
    input  wire signed [31:0]                    i_vertex_x,
    input  wire signed [31:0]                    i_vertex_y,
    input  wire signed [31:0]                    i_vertex_z,
    input  wire signed [15:0]                    i_normal_x,
    input  wire signed [15:0]                    i_normal_y,
    input  wire signed [15:0]                    i_normal_z,
    input  wire                                  i_last_vertex,
    output logic                                 o_res_valid,
    input  wire                                  i_res_ready,
    output logic signed [31:0]                   o_outline_x,
    output logic signed [31:0]                   o_outline_y,
    output logic signed [31:0]                   o_outline_z,
    output logic [15:0]                          o_shade_coord,
    output logic                                 o_shade_valid,
    output logic                                 o_last_out
);

    localparam int MAG_W  = vcso_pkg::MAG_W;
    localparam int VEC_W  = vcso_pkg::VEC_W;
    localparam int SQ_W   = vcso_pkg::SQ_W;
    localparam int PR_W   = vcso_pkg::PR_W;
    localparam int L2_W   = vcso_pkg::L2_W;
    localparam int P_W    = vcso_pkg::P_W;
    localparam int RAD_W  = vcso_pkg::RAD_W;
    localparam int ROOT_W = vcso_pkg::ROOT_W;
    localparam int NUM_W  = vcso_pkg::NUM_W;
    localparam int QUO_W  = vcso_pkg::QUO_W;
    localparam int PB     = vcso_pkg::PRESCALE_BITS;

    logic signed [31:0] r_light_x;
    logic signed [31:0] r_light_y;
    logic signed [31:0] r_light_z;
    logic               r_directional;
    logic               r_shading;

    logic               w_en;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x     <= '0;
            r_light_y     <= '0;
            r_light_z     <= '0;
            r_directional <= 1'b0;
            r_shading     <= 1'b0;
        end else if (i_cfg_wr) begin
            unique case (vcso_pkg::t_cfg_idx'(i_cfg_idx))
                vcso_pkg::CFG_LIGHT_X:     r_light_x     <= i_cfg_data;
                vcso_pkg::CFG_LIGHT_Y:     r_light_y     <= i_cfg_data;
                vcso_pkg::CFG_LIGHT_Z:     r_light_z     <= i_cfg_data;
                vcso_pkg::CFG_DIRECTIONAL: r_directional <= i_cfg_data[0];
                vcso_pkg::CFG_SHADING:     r_shading     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_vtx_ready = w_en;

    // stage a: light vector magnitude, outline offset
    logic signed [31:0]  w_pos   [3];
    logic signed [31:0]  w_light [3];
    logic signed [15:0]  w_nrm   [3];
    logic signed [MAG_W-1:0] w_l [3];
    logic [MAG_W-1:0]    w_mag   [3];
    logic signed [31:0]  w_prod  [3];
    logic signed [31:0]  w_rnd   [3];

    logic                r_a_valid;
    logic [MAG_W-1:0]    r_a_mag  [3];
    logic                r_a_neg  [3];
    logic signed [15:0]  r_a_nrm  [3];
    logic signed [31:0]  r_a_pos  [3];
    logic signed [15:0]  r_a_dlt  [3];
    logic                r_a_last;
    logic                r_a_shade;

    always_comb begin
        w_pos[0]   = i_vertex_x;
        w_pos[1]   = i_vertex_y;
        w_pos[2]   = i_vertex_z;
        w_light[0] = r_light_x;
        w_light[1] = r_light_y;
        w_light[2] = r_light_z;
        w_nrm[0]   = i_normal_x;
        w_nrm[1]   = i_normal_y;
        w_nrm[2]   = i_normal_z;
        for (int i = 0; i < 3; i++) begin
            if (r_directional) begin
                w_l[i] = MAG_W'(w_light[i]);
            end else begin
                w_l[i] = MAG_W'(w_light[i]) - MAG_W'(w_pos[i]);
            end
            w_mag[i]  = w_l[i][MAG_W-1] ? MAG_W'(-w_l[i]) : MAG_W'(w_l[i]);
            w_prod[i] = 32'(w_nrm[i]) * 32'(vcso_pkg::OUTLINE_SCALE);
            w_rnd[i]  = w_prod[i] + 32'(vcso_pkg::OUTLINE_ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_vtx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_mag[i] <= w_mag[i];
                r_a_neg[i] <= w_l[i][MAG_W-1];
                r_a_nrm[i] <= w_nrm[i];
                r_a_pos[i] <= w_pos[i];
                r_a_dlt[i] <= w_rnd[i][31:16];
            end
            r_a_last  <= i_last_vertex;
            r_a_shade <= r_shading;
        end
    end

    // stage b: prescale, outline add with saturation
    logic [MAG_W-1:0]    w_or;
    logic [3:0]          w_shift;
    logic [MAG_W-1:0]    w_shr  [3];
    logic [VEC_W-1:0]    w_m    [3];
    logic signed [VEC_W-1:0] w_v [3];
    logic signed [32:0]  w_sum  [3];
    logic signed [31:0]  w_sat  [3];
    vcso_pkg::t_side     w_b_side;

    logic                r_b_valid;
    logic signed [VEC_W-1:0] r_b_v [3];
    logic signed [15:0]  r_b_nrm [3];
    vcso_pkg::t_side     r_b_side;

    always_comb begin
        w_or    = r_a_mag[0] | r_a_mag[1] | r_a_mag[2];
        w_shift = '0;
        for (int k = PB; k < MAG_W; k++) begin
            if (w_or[k]) begin
                w_shift = 4'(k - PB + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            w_shr[i] = r_a_mag[i] >> w_shift;
            w_m[i]   = {1'b0, w_shr[i][PB-1:0]};
            w_v[i]   = r_a_neg[i] ? VEC_W'(-w_m[i]) : VEC_W'(w_m[i]);
            w_sum[i] = 33'(r_a_pos[i]) + 33'(r_a_dlt[i]);
            if (w_sum[i][32] != w_sum[i][31]) begin
                w_sat[i] = w_sum[i][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                w_sat[i] = w_sum[i][31:0];
            end
        end
        w_b_side.outline_x = w_sat[0];
        w_b_side.outline_y = w_sat[1];
        w_b_side.outline_z = w_sat[2];
        w_b_side.last      = r_a_last;
        w_b_side.shade_en  = r_a_shade;
        w_b_side.zero      = 1'b0;
        w_b_side.neg       = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_b_v[i]   <= w_v[i];
                r_b_nrm[i] <= r_a_nrm[i];
            end
            r_b_side <= w_b_side;
        end
    end

    // stage c: squares and products
    logic signed [2*VEC_W-1:0] w_sq [3];
    logic signed [PR_W-1:0]    w_pr [3];

    logic                r_c_valid;
    logic [SQ_W-1:0]     r_c_sq [3];
    logic signed [PR_W-1:0] r_c_pr [3];
    vcso_pkg::t_side     r_c_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i] = r_b_v[i] * r_b_v[i];
            w_pr[i] = r_b_v[i] * r_b_nrm[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_c_sq[i] <= w_sq[i][SQ_W-1:0];
                r_c_pr[i] <= w_pr[i];
            end
            r_c_side <= r_b_side;
        end
    end

    // stage d: squared length and dot product
    logic [L2_W-1:0]        w_l2;
    logic signed [P_W-1:0]  w_p;
    vcso_pkg::t_side        w_d_side;

    logic                   r_d_valid;
    logic [RAD_W-1:0]       r_d_rad;
    logic [NUM_W-1:0]       r_d_num;
    vcso_pkg::t_side        r_d_side;

    always_comb begin
        w_l2 = L2_W'(r_c_sq[0]) + L2_W'(r_c_sq[1]) + L2_W'(r_c_sq[2]);
        w_p  = P_W'(r_c_pr[0]) + P_W'(r_c_pr[1]) + P_W'(r_c_pr[2]);
        w_d_side      = r_c_side;
        w_d_side.zero = (r_c_sq[0] | r_c_sq[1] | r_c_sq[2]) == '0;
        w_d_side.neg  = w_p[P_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_rad  <= {w_l2, 12'b0};
            r_d_num  <= {w_p[P_W-2:0], 8'b0};
            r_d_side <= w_d_side;
        end
    end

    // length and quotient
    logic                   w_sq_valid;
    logic [ROOT_W-1:0]      w_root;
    logic [NUM_W-1:0]       w_sq_num;
    vcso_pkg::t_side        w_sq_side;
    logic                   w_dv_valid;
    logic [QUO_W-1:0]       w_quo;
    vcso_pkg::t_side        w_dv_side;

    vcso_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_valid),
        .i_rad   (r_d_rad),
        .i_num   (r_d_num),
        .i_side  (r_d_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_num   (w_sq_num),
        .o_side  (w_sq_side)
    );

    vcso_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_num   (w_sq_num),
        .i_den   (w_root),
        .i_side  (w_sq_side),
        .o_valid (w_dv_valid),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // clamp and output register
    logic        w_over;
    logic        w_one;
    logic [15:0] w_coord;

    logic        r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic signed [31:0] r_out_z;
    logic [15:0] r_out_coord;
    logic        r_out_sv;
    logic        r_out_last;

    always_comb begin
        w_over = w_quo[QUO_W-1] | (w_quo[16] & (|w_quo[15:0]));
        w_one  = w_quo[16] & ~(|w_quo[15:0]);
        priority if (!w_dv_side.shade_en || w_dv_side.zero) begin
            w_coord = '0;
        end else if (w_dv_side.neg) begin
            w_coord = vcso_pkg::SHADE_LOW;
        end else if (w_over) begin
            w_coord = vcso_pkg::SHADE_HIGH;
        end else if (w_one) begin
            w_coord = vcso_pkg::SHADE_MAX;
        end else begin
            w_coord = w_quo[15:0];
        end
    end

    assign w_en = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x     <= w_dv_side.outline_x;
            r_out_y     <= w_dv_side.outline_y;
            r_out_z     <= w_dv_side.outline_z;
            r_out_coord <= w_coord;
            r_out_sv    <= w_dv_side.shade_en;
            r_out_last  <= w_dv_side.last;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_outline_x   = r_out_x;
    assign o_outline_y   = r_out_y;
    assign o_outline_z   = r_out_z;
    assign o_shade_coord = r_out_coord;
    assign o_shade_valid = r_out_sv;
    assign o_last_out    = r_out_last;

    a_stall_holds_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_a_valid) |=> r_a_valid)
        else $error("front stage lost a request under stall");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_shade_valid) |-> (o_shade_coord == '0))
        else $error("shade coordinate nonzero with shading off");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_stall_holds_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_d_valid) |=> (r_d_valid && $stable(r_d_rad) && $stable(r_d_num)))
        else $error("length stage changed under stall");

endmodule

`default_nettype wire
